FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: hw/rtl/lssrm_pkg.sv
// shared types and constants of the log sine sweep response meter
// no dependencies
`default_nettype none

package lssrm_pkg;

  // default sizes
  localparam int CYCLES_PER_POINT_DEF = 5;
  localparam int SINE_DEPTH_DEF       = 1024;
  localparam int POW_DEPTH_DEF        = 4096;

  // divider geometry: 66-bit dividend, 64-bit divisor
  localparam int DIV_NW = 66;
  localparam int DIV_DW = 64;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_AMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_LOG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LOG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_TICKS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 3'd6;
  localparam int CFG_DATA_W = 32;

  // sweep mode codes (code 3 behaves as off)
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_STEPPED = 2'd1;
  localparam logic [1:0] MODE_CONT    = 2'd2;

  // stepped scan phase
  typedef enum logic [1:0] {
    SCAN_OFF    = 2'd0,
    SCAN_RUN    = 2'd1,
    SCAN_NEXT   = 2'd2,
    SCAN_FINISH = 2'd3
  } scan_e;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_XDIV,
    OP_SET_X,
    OP_TRIG,
    OP_NEXT_X,
    OP_NO_NEXT,
    OP_END_SCAN,
    OP_POW,
    OP_MUL_P,
    OP_SDIV,
    OP_SET_STEP,
    OP_LDIV,
    OP_SET_LEN_MAX,
    OP_SET_LEN,
    OP_CONT_ACC,
    OP_STEP_ACC,
    OP_SINE,
    OP_DRIVE_MUL,
    OP_DRIVE_SET,
    OP_OUT_LOAD
  } dp_op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_XWAIT,
    ST_POW,
    ST_MULP,
    ST_SDIV,
    ST_SWAIT,
    ST_LEN,
    ST_LWAIT,
    ST_CACC,
    ST_SINE,
    ST_DMUL,
    ST_DSET,
    ST_OUT
  } ctrl_state_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic [1:0] mode;
    scan_e      scan;
    logic       log_lt_stop;
    logic       step_zero;
    logic       div_done;
    logic       out_busy;
  } dp_status_t;

  // input word
  typedef struct packed {
    logic signed [15:0] response_sample;
    logic               start_request;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [15:0] drive_sample;
    logic signed [15:0] current_log_freq;
    logic [14:0]        response_amplitude;
    logic               point_done;
    logic               sweep_done;
  } out_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lssrm_div.sv
// restoring unsigned divider, one quotient bit per cycle
// uses lssrm_pkg for the operand widths
`default_nettype none

module lssrm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [lssrm_pkg::DIV_NW-1:0] dividend_i,
  input  wire logic [lssrm_pkg::DIV_DW-1:0] divisor_i,
  output logic                              done_o,
  output logic [lssrm_pkg::DIV_NW-1:0]      quotient_o
);

  localparam int Nw = lssrm_pkg::DIV_NW;
  localparam int Dw = lssrm_pkg::DIV_DW;
  localparam int Cw = $clog2(Nw + 1);

  logic [Dw:0]   rem_q, rem_d, trial;
  logic [Nw-1:0] quo_q, quo_d;
  logic [Dw-1:0] div_q;
  logic [Cw-1:0] cnt_q;
  logic          busy_q, done_q;

  // one shift, compare and subtract step
  always_comb begin
    trial = {rem_q[Dw-1:0], quo_q[Nw-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = trial - {1'b0, div_q};
      quo_d = {quo_q[Nw-2:0], 1'b1};
    end else begin
      rem_d = trial;
      quo_d = {quo_q[Nw-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= Cw'(Nw);
    end else if (busy_q) begin
      cnt_q <= cnt_q - Cw'(1);
      if (cnt_q == Cw'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lssrm_ctrl.sv
// sequencing state machine of the response meter
// uses lssrm_pkg for states, operations and status
`default_nettype none

module lssrm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lssrm_pkg::dp_status_t status_i,
  output lssrm_pkg::dp_op_e          op_o
);

  lssrm_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lssrm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and operation
  always_comb begin
    state_d    = state_q;
    op_o       = lssrm_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      lssrm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = lssrm_pkg::OP_CAPTURE;
          state_d = lssrm_pkg::ST_DECODE;
        end
      end
      lssrm_pkg::ST_DECODE: begin
        if (status_i.mode == lssrm_pkg::MODE_CONT) begin
          op_o    = lssrm_pkg::OP_XDIV;
          state_d = lssrm_pkg::ST_XWAIT;
        end else if (status_i.mode == lssrm_pkg::MODE_STEPPED) begin
          unique case (status_i.scan)
            lssrm_pkg::SCAN_OFF: begin
              op_o    = lssrm_pkg::OP_TRIG;
              state_d = lssrm_pkg::ST_OUT;
            end
            lssrm_pkg::SCAN_RUN: begin
              op_o    = lssrm_pkg::OP_STEP_ACC;
              state_d = lssrm_pkg::ST_SINE;
            end
            lssrm_pkg::SCAN_NEXT: begin
              if (status_i.log_lt_stop) begin
                op_o    = lssrm_pkg::OP_NEXT_X;
                state_d = lssrm_pkg::ST_POW;
              end else begin
                op_o    = lssrm_pkg::OP_NO_NEXT;
                state_d = lssrm_pkg::ST_OUT;
              end
            end
            lssrm_pkg::SCAN_FINISH: begin
              op_o    = lssrm_pkg::OP_END_SCAN;
              state_d = lssrm_pkg::ST_OUT;
            end
            default: state_d = lssrm_pkg::ST_OUT;
          endcase
        end else begin
          state_d = lssrm_pkg::ST_OUT;
        end
      end
      lssrm_pkg::ST_XWAIT: begin
        if (status_i.div_done) begin
          op_o    = lssrm_pkg::OP_SET_X;
          state_d = lssrm_pkg::ST_POW;
        end
      end
      lssrm_pkg::ST_POW: begin
        op_o    = lssrm_pkg::OP_POW;
        state_d = lssrm_pkg::ST_MULP;
      end
      lssrm_pkg::ST_MULP: begin
        op_o    = lssrm_pkg::OP_MUL_P;
        state_d = lssrm_pkg::ST_SDIV;
      end
      lssrm_pkg::ST_SDIV: begin
        op_o    = lssrm_pkg::OP_SDIV;
        state_d = lssrm_pkg::ST_SWAIT;
      end
      lssrm_pkg::ST_SWAIT: begin
        if (status_i.div_done) begin
          op_o    = lssrm_pkg::OP_SET_STEP;
          state_d = (status_i.mode == lssrm_pkg::MODE_CONT) ? lssrm_pkg::ST_CACC
                                                            : lssrm_pkg::ST_LEN;
        end
      end
      lssrm_pkg::ST_LEN: begin
        if (status_i.step_zero) begin
          op_o    = lssrm_pkg::OP_SET_LEN_MAX;
          state_d = lssrm_pkg::ST_OUT;
        end else begin
          op_o    = lssrm_pkg::OP_LDIV;
          state_d = lssrm_pkg::ST_LWAIT;
        end
      end
      lssrm_pkg::ST_LWAIT: begin
        if (status_i.div_done) begin
          op_o    = lssrm_pkg::OP_SET_LEN;
          state_d = lssrm_pkg::ST_OUT;
        end
      end
      lssrm_pkg::ST_CACC: begin
        op_o    = lssrm_pkg::OP_CONT_ACC;
        state_d = lssrm_pkg::ST_SINE;
      end
      lssrm_pkg::ST_SINE: begin
        op_o    = lssrm_pkg::OP_SINE;
        state_d = lssrm_pkg::ST_DMUL;
      end
      lssrm_pkg::ST_DMUL: begin
        op_o    = lssrm_pkg::OP_DRIVE_MUL;
        state_d = lssrm_pkg::ST_DSET;
      end
      lssrm_pkg::ST_DSET: begin
        op_o    = lssrm_pkg::OP_DRIVE_SET;
        state_d = lssrm_pkg::ST_OUT;
      end
      lssrm_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          op_o    = lssrm_pkg::OP_OUT_LOAD;
          state_d = lssrm_pkg::ST_IDLE;
        end
      end
      default: state_d = lssrm_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lssrm_dp.sv
// datapath: registers, sweep state, tables, multipliers and shared divider
// uses lssrm_pkg and instantiates lssrm_div
`default_nettype none

module lssrm_dp #(
  parameter int CYCLES_PER_POINT = lssrm_pkg::CYCLES_PER_POINT_DEF,
  parameter int SINE_TABLE_DEPTH = lssrm_pkg::SINE_DEPTH_DEF,
  parameter int POW_TABLE_DEPTH  = lssrm_pkg::POW_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lssrm_pkg::dp_op_e                    op_i,
  output lssrm_pkg::dp_status_t                     status_o,
  input  wire lssrm_pkg::in_word_t                  in_word_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output lssrm_pkg::out_word_t                      out_word_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lssrm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [lssrm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int Nw     = lssrm_pkg::DIV_NW;
  localparam int Dw     = lssrm_pkg::DIV_DW;
  localparam int SinAw  = $clog2(SINE_TABLE_DEPTH);
  localparam int PowAw  = $clog2(POW_TABLE_DEPTH);
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Ln10Q30   = 64'd2472381918;
  localparam longint unsigned OneQ30    = 64'd1073741824;
  localparam longint unsigned TaylorDiv [7] = '{6, 20, 42, 72, 110, 156, 210};
  localparam longint unsigned KDiv [24] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12,
                                            13, 14, 15, 16, 17, 18, 19, 20, 21, 22,
                                            23, 24};
  localparam logic signed [15:0] RmaxRst = 16'sh8000;
  localparam logic signed [15:0] RminRst = 16'sh7FFF;

  // sine entry in q.30 from a truncated series on a quarter wave
  function automatic logic signed [31:0] sine_entry(input longint unsigned idx);
    longint unsigned q4, quad, r, a, term;
    longint          sum;
    q4   = idx * 4;
    quad = q4 / SINE_TABLE_DEPTH;
    r    = q4 % SINE_TABLE_DEPTH;
    if (quad[0]) r = SINE_TABLE_DEPTH - r;
    a    = (HalfPiQ30 * r) / SINE_TABLE_DEPTH;
    term = a;
    sum  = longint'(a);
    for (int k = 1; k <= 7; k++) begin
      term = (((term * a) >> 30) * a) >> 30;
      term = term / TaylorDiv[k-1];
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(OneQ30)) sum = longint'(OneQ30);
    if (quad >= 2) sum = -sum;
    return 32'(sum);
  endfunction

  // 10^(j/depth) in q.28 from a series of e^w in q.30
  function automatic logic [31:0] pow_entry(input longint unsigned j);
    longint unsigned w, term, sum;
    w    = (Ln10Q30 * j) / POW_TABLE_DEPTH;
    term = OneQ30;
    sum  = OneQ30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * w) >> 30) / KDiv[k-1];
      sum  = sum + term;
    end
    return 32'(sum >> 2);
  endfunction

  // 10^(17-h), the divisor for exponent decade nibble h
  function automatic logic [Dw-1:0] dec_entry(input int h);
    logic [Dw-1:0] v;
    v = Dw'(1);
    for (int n = 0; n < 17 - h; n++) v = v * Dw'(10);
    return v;
  endfunction

  // constant tables
  logic signed [31:0] sine_rom [SINE_TABLE_DEPTH];
  logic [31:0]        pow_rom  [POW_TABLE_DEPTH];
  logic [Dw-1:0]      dec_rom  [16];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
    localparam logic signed [31:0] SineVal = sine_entry(longint'(g));
    assign sine_rom[g] = SineVal;
  end
  for (genvar g = 0; g < POW_TABLE_DEPTH; g++) begin : g_pow
    localparam logic [31:0] PowVal = pow_entry(longint'(g));
    assign pow_rom[g] = PowVal;
  end
  for (genvar g = 0; g < 16; g++) begin : g_dec
    localparam logic [Dw-1:0] DecVal = dec_entry(g);
    assign dec_rom[g] = DecVal;
  end

  // configuration registers
  logic [1:0]         mode_q;
  logic [14:0]        amp_q;
  logic signed [15:0] start_q, stop_q;
  logic [12:0]        lstep_q;
  logic [31:0]        ticks_q;
  logic [29:0]        period_q;

  // sweep state
  logic [31:0]        acc_q, step_q, elapsed_q, pticks_q, plen_q;
  logic signed [15:0] logf_q, rmax_q, rmin_q;
  logic [14:0]        held_q;
  logic               wrapped_q, prev_q;
  lssrm_pkg::scan_e   scan_q;

  // per-word working registers
  logic signed [15:0] samp_q;
  logic               req_q, xneg_q;
  logic [31:0]        e_q;
  logic [Dw-1:0]      dec_q;
  logic [61:0]        p_q;
  logic signed [31:0] sine_q;
  logic [45:0]        prod_q;
  logic signed [15:0] drive_q;
  logic               pdone_q, sdone_q;
  lssrm_pkg::out_word_t out_q;
  logic               out_valid_q;

  // divider hookup
  logic          div_start, div_done;
  logic [Nw-1:0] div_dividend, div_quot;
  logic [Dw-1:0] div_divisor;

  // continuous exponent terms
  logic signed [16:0] span;
  logic [15:0]        span_mag;
  logic [47:0]        span_prod;
  logic [16:0]        q_mag;
  logic signed [18:0] q_signed, x_wide;
  logic signed [15:0] x_sat;

  always_comb begin
    span      = 17'({stop_q[15], stop_q}) - 17'({start_q[15], start_q});
    span_mag  = span[16] ? 16'(-span) : span[15:0];
    span_prod = 48'(span_mag) * 48'(elapsed_q);
    q_mag     = (|div_quot[Nw-1:17]) ? 17'h1FFFF : div_quot[16:0];
    q_signed  = xneg_q ? -19'(q_mag) : 19'(q_mag);
    x_wide    = 19'(start_q) + q_signed;
    if (x_wide > 19'sd32767)       x_sat = 16'sh7FFF;
    else if (x_wide < -19'sd32768) x_sat = 16'sh8000;
    else                           x_sat = x_wide[15:0];
  end

  // stepped next exponent, saturated
  logic signed [16:0] nx_wide;
  logic signed [15:0] nx_sat;
  assign nx_wide = 17'(logf_q) + 17'({4'b0, lstep_q});
  assign nx_sat  = (nx_wide > 17'sd32767) ? 16'sh7FFF : nx_wide[15:0];

  // table indexes
  logic [15:0]       u_ofs;
  logic [29:0]       pow_prod;
  logic [PowAw-1:0]  pow_idx;
  logic [47:0]       sin_prod;
  logic [SinAw-1:0]  sin_idx;
  assign u_ofs    = {~logf_q[15], logf_q[14:0]};
  assign pow_prod = 30'(u_ofs[11:0]) * 30'(POW_TABLE_DEPTH);
  assign pow_idx  = pow_prod[12 +: PowAw];
  assign sin_prod = 48'(acc_q) * 48'(SINE_TABLE_DEPTH);
  assign sin_idx  = sin_prod[32 +: SinAw];

  // phase accumulator step with overflow to zero
  logic [32:0] acc_sum;
  assign acc_sum = {1'b0, acc_q} + {1'b0, step_q};

  // response extremes
  logic signed [15:0] nmax, nmin;
  logic [16:0]        ext_span;
  assign nmax     = (samp_q > rmax_q) ? samp_q : rmax_q;
  assign nmin     = (samp_q < rmin_q) ? samp_q : rmin_q;
  assign ext_span = 17'({nmax[15], nmax}) - 17'({nmin[15], nmin});

  // drive rounding
  logic [30:0] sine_mag;
  logic [46:0] rnd;
  logic [15:0] drv_mag;
  assign sine_mag = sine_q[31] ? 31'(-sine_q) : sine_q[30:0];
  assign rnd      = {1'b0, prod_q} + 47'(64'd1 << 29);
  assign drv_mag  = rnd[45:30];

  // end of continuous sweep and end of stepped point
  logic cont_end, point_end;
  assign cont_end  = (mode_q == lssrm_pkg::MODE_CONT) && !(elapsed_q < ticks_q);
  assign point_end = (mode_q == lssrm_pkg::MODE_STEPPED) && (pticks_q > plen_q) && wrapped_q;

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = Nw'(span_prod);
    div_divisor  = (ticks_q == '0) ? Dw'(1) : Dw'(ticks_q);
    unique case (op_i)
      lssrm_pkg::OP_XDIV: begin
        div_start = 1'b1;
      end
      lssrm_pkg::OP_SDIV: begin
        div_start    = 1'b1;
        div_dividend = {p_q, 4'b0};
        div_divisor  = dec_q;
      end
      lssrm_pkg::OP_LDIV: begin
        div_start    = 1'b1;
        div_dividend = Nw'(CYCLES_PER_POINT) << 32;
        div_divisor  = Dw'(step_q);
      end
      default: ;
    endcase
  end

  lssrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  logic [31:0] quot_sat;
  assign quot_sat = (|div_quot[Nw-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];

  // configuration and sweep state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lssrm_pkg::MODE_CONT;
      amp_q     <= 15'd3;
      start_q   <= -16'sd8192;
      stop_q    <= 16'sd8192;
      lstep_q   <= 13'd410;
      ticks_q   <= 32'd50000;
      period_q  <= 30'd1000000;
      acc_q     <= '0;
      step_q    <= '0;
      logf_q    <= '0;
      elapsed_q <= '0;
      pticks_q  <= '0;
      plen_q    <= '0;
      rmax_q    <= RmaxRst;
      rmin_q    <= RminRst;
      held_q    <= '0;
      wrapped_q <= 1'b0;
      scan_q    <= lssrm_pkg::SCAN_OFF;
      prev_q    <= 1'b0;
    end else begin
      unique case (op_i)
        lssrm_pkg::OP_SET_X: logf_q <= x_sat;
        lssrm_pkg::OP_TRIG: begin
          if (req_q && !prev_q) begin
            logf_q <= start_q;
            acc_q  <= '0;
            rmax_q <= RmaxRst;
            rmin_q <= RminRst;
            scan_q <= lssrm_pkg::SCAN_NEXT;
          end
          prev_q <= req_q;
        end
        lssrm_pkg::OP_NEXT_X: begin
          logf_q    <= nx_sat;
          pticks_q  <= '0;
          wrapped_q <= 1'b0;
          scan_q    <= lssrm_pkg::SCAN_RUN;
        end
        lssrm_pkg::OP_NO_NEXT: begin
          logf_q <= start_q;
          scan_q <= lssrm_pkg::SCAN_FINISH;
        end
        lssrm_pkg::OP_END_SCAN: begin
          scan_q <= lssrm_pkg::SCAN_OFF;
          mode_q <= lssrm_pkg::MODE_OFF;
        end
        lssrm_pkg::OP_SET_STEP:    step_q <= quot_sat;
        lssrm_pkg::OP_SET_LEN_MAX: plen_q <= 32'hFFFF_FFFF;
        lssrm_pkg::OP_SET_LEN:     plen_q <= quot_sat;
        lssrm_pkg::OP_CONT_ACC:    acc_q  <= acc_sum[32] ? '0 : acc_sum[31:0];
        lssrm_pkg::OP_STEP_ACC: begin
          acc_q  <= acc_sum[32] ? '0 : acc_sum[31:0];
          if (acc_sum[32]) wrapped_q <= 1'b1;
          rmax_q <= nmax;
          rmin_q <= nmin;
          held_q <= ext_span[15:1];
          if (pticks_q != 32'hFFFF_FFFF) pticks_q <= pticks_q + 32'd1;
        end
        lssrm_pkg::OP_DRIVE_SET: begin
          if (mode_q == lssrm_pkg::MODE_CONT) begin
            if (cont_end) begin
              acc_q     <= '0;
              elapsed_q <= '0;
              mode_q    <= lssrm_pkg::MODE_OFF;
            end else begin
              elapsed_q <= elapsed_q + 32'd1;
            end
          end else if (point_end) begin
            pticks_q  <= '0;
            acc_q     <= '0;
            rmax_q    <= RmaxRst;
            rmin_q    <= RminRst;
            wrapped_q <= 1'b0;
            scan_q    <= lssrm_pkg::SCAN_NEXT;
          end
        end
        default: ;
      endcase
      // the user must make register writes only while idle; the block itself does not enforce it
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lssrm_pkg::REG_SWEEP_MODE:  mode_q   <= cfg_data_i[1:0];
          lssrm_pkg::REG_DRIVE_AMP:   amp_q    <= cfg_data_i[14:0];
          lssrm_pkg::REG_START_LOG:   start_q  <= cfg_data_i[15:0];
          lssrm_pkg::REG_STOP_LOG:    stop_q   <= cfg_data_i[15:0];
          lssrm_pkg::REG_LOG_STEP:    lstep_q  <= cfg_data_i[12:0];
          lssrm_pkg::REG_SWEEP_TICKS: ticks_q  <= cfg_data_i[31:0];
          lssrm_pkg::REG_TICK_PERIOD: period_q <= cfg_data_i[29:0];
          default: ;
        endcase
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      lssrm_pkg::OP_CAPTURE: begin
        samp_q  <= in_word_i.response_sample;
        req_q   <= in_word_i.start_request;
        drive_q <= '0;
        pdone_q <= 1'b0;
        sdone_q <= 1'b0;
      end
      lssrm_pkg::OP_XDIV:      xneg_q <= span[16];
      lssrm_pkg::OP_END_SCAN:  sdone_q <= 1'b1;
      lssrm_pkg::OP_POW: begin
        e_q   <= pow_rom[pow_idx];
        dec_q <= dec_rom[u_ofs[15:12]];
      end
      lssrm_pkg::OP_MUL_P:     p_q <= 62'(e_q) * 62'(period_q);
      lssrm_pkg::OP_SINE:      sine_q <= sine_rom[sin_idx];
      lssrm_pkg::OP_DRIVE_MUL: prod_q <= 46'(amp_q) * 46'(sine_mag);
      lssrm_pkg::OP_DRIVE_SET: begin
        if (cont_end) begin
          drive_q <= '0;
          sdone_q <= 1'b1;
        end else if (point_end) begin
          drive_q <= '0;
          pdone_q <= 1'b1;
        end else begin
          drive_q <= sine_q[31] ? 16'(~drv_mag + 16'd1) : drv_mag;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == lssrm_pkg::OP_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == lssrm_pkg::OP_OUT_LOAD) begin
      out_q.drive_sample       <= drive_q;
      out_q.current_log_freq   <= logf_q;
      out_q.response_amplitude <= held_q;
      out_q.point_done         <= pdone_q;
      out_q.sweep_done         <= sdone_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // status to the controller
  always_comb begin
    status_o.mode        = mode_q;
    status_o.scan        = scan_q;
    status_o.log_lt_stop = logf_q < stop_q;
    status_o.step_zero   = step_q == '0;
    status_o.div_done    = div_done;
    status_o.out_busy    = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/log_sine_sweep_response_meter_core.sv
// top level of the log sine sweep response meter: controller plus datapath
// uses lssrm_pkg, lssrm_ctrl, lssrm_dp and assert_macros.svh
//
//   port group   direction  handshake               payload
//   in_*         input      in_valid_i/in_ready_o   in_word_i  (in_word_t)
//   out_*        output     out_valid_o/out_ready_i out_word_o (out_word_t)
//   cfg_*        input      cfg_we_i                cfg_index_i, cfg_data_i
//
// one word at a time; a continuous word passes twice through the 66-step
// shared divider, a stepped frequency change twice as well (once when the
// phase step is zero), and a stepped point tick or any other word not at all.
// the next word is taken while a finished result waits in the output register;
// a result still waiting when the next one is ready holds the controller.
// reset restores the register defaults and clears all sweep state.
`default_nettype none

`include "assert_macros.svh"

module log_sine_sweep_response_meter_core #(
  parameter int CYCLES_PER_POINT = lssrm_pkg::CYCLES_PER_POINT_DEF,
  parameter int SINE_TABLE_DEPTH = lssrm_pkg::SINE_DEPTH_DEF,
  parameter int POW_TABLE_DEPTH  = lssrm_pkg::POW_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lssrm_pkg::in_word_t              in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lssrm_pkg::out_word_t                  out_word_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lssrm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lssrm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  lssrm_pkg::dp_status_t status;
  lssrm_pkg::dp_op_e     op;

  lssrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  lssrm_dp #(
    .CYCLES_PER_POINT (CYCLES_PER_POINT),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .POW_TABLE_DEPTH  (POW_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // checks
  `ASSERT_PROP(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "word overlap")
  `ASSERT_NEVER(a_done_excl, clk_i, rst_ni, out_valid_o && out_word_o.point_done && out_word_o.sweep_done, "both done flags")
  `ASSERT_NEVER(a_pdone_quiet, clk_i, rst_ni, out_valid_o && out_word_o.point_done && (out_word_o.drive_sample != 16'sd0), "drive at point end")
  `ASSERT_NEVER(a_sdone_quiet, clk_i, rst_ni, out_valid_o && out_word_o.sweep_done && (out_word_o.drive_sample != 16'sd0), "drive at sweep end")

endmodule

`default_nettype wire

FILE: tb/lssrm_checker.sv
// checker for the log sine sweep response meter: mirrors the register writes,
// predicts every result word and compares it with what the core hands out
// depends on lssrm_pkg
`timescale 1ns / 1ps

module lssrm_checker
  import lssrm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned LN10_Q30    = 64'd2472381918;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int              PERIODS     = 5;

  // register copies
  logic [1:0]         mode_q;
  logic [14:0]        amp_q;
  logic signed [15:0] start_q, stop_q;
  logic [12:0]        lstep_q;
  logic [31:0]        ticks_q;
  logic [29:0]        period_q;

  // sweep state copies
  logic [31:0] acc, step, elapsed, pticks, plen;
  int          freq_pos, rmax, rmin;
  logic [14:0] held_amp;
  logic        wrapped, prev_req, finished;
  scan_e       scan;

  out_word_t expected_words[$];

  // quarter wave sine in Q.30 from the table index of the phase
  function automatic longint signed sine_q30(logic [31:0] ph);
    longint unsigned i, q4, quad, r, a, term;
    longint signed sum;
    i = longint'(ph) >> 22;
    q4 = i * 4;
    quad = q4 / 1024;
    r = q4 % 1024;
    if (quad[0]) r = 1024 - r;
    a = (HALF_PI_Q30 * r) / 1024;
    term = a;
    sum = a;
    for (int k = 1; k <= 7; k++) begin
      term = (((term * a) >> 30) * a) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = ONE_Q30;
    return (quad >= 2) ? -sum : sum;
  endfunction

  function automatic int drive_of(logic [31:0] ph);
    longint signed s;
    longint unsigned mag;
    int v;
    s = sine_q30(ph);
    mag = (s < 0) ? -s : s;
    v = int'((longint'(amp_q) * mag + (ONE_Q30 >> 1)) >> 30);
    return (s < 0) ? -v : v;
  endfunction

  // 10^(j/4096) in Q.28
  function automatic longint unsigned pow10_q28(longint unsigned j);
    longint unsigned w, term, sum;
    w = (LN10_Q30 * j) / 4096;
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * w) >> 30) / longint'(k);
      sum = sum + term;
    end
    return sum >> 2;
  endfunction

  // phase increment per tick for a Q.12 decade exponent
  function automatic logic [31:0] phase_inc(int x);
    longint unsigned u, f, p, dv, q, r;
    int d;
    u = longint'(x + 32768) & 64'hFFFF;
    d = int'(u >> 12) - 8;
    f = u & 64'd4095;
    p = pow10_q28(f) * longint'(period_q);
    dv = 1;
    for (int n = 0; n < 9 - d; n++) dv = dv * 10;
    q = p / dv;
    r = p % dv;
    if (q >= (64'd1 << 28)) return 32'hFFFF_FFFF;
    return 32'((q << 4) + ((r << 4) / dv));
  endfunction

  function automatic logic [31:0] point_len(logic [31:0] st);
    longint unsigned l;
    if (st == 0) return 32'hFFFF_FFFF;
    l = (longint'(PERIODS) << 32) / longint'(st);
    return (l > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(l);
  endfunction

  // one tick of the meter: updates the mirrored state, returns the result word
  task automatic meter_tick(input in_word_t w, output out_word_t res);
    int sample, drive, stp, ed;
    longint signed x, dv;
    logic [31:0] nxt, diff;
    logic pdone, sdone;
    sample = int'(w.response_sample);
    stp = int'(start_q);
    ed = int'(stop_q);
    drive = 0;
    pdone = 1'b0;
    sdone = 1'b0;
    if (mode_q == MODE_CONT) begin
      dv = (ticks_q != 0) ? longint'(ticks_q) : 1;
      x = longint'(stp) + (longint'(ed - stp) * longint'(elapsed)) / dv;
      if (elapsed == 0) finished = 1'b0;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      freq_pos = int'(x);
      step = phase_inc(freq_pos);
      nxt = acc + step;
      acc = (nxt < acc) ? 32'd0 : nxt;
      drive = drive_of(acc);
      if (elapsed < ticks_q) begin
        elapsed++;
      end else begin
        drive = 0;
        acc = 0;
        elapsed = 0;
        mode_q = MODE_OFF;
        sdone = 1'b1;
        finished = 1'b1;
      end
    end else if (mode_q == MODE_STEPPED) begin
      case (scan)
        SCAN_OFF: begin
          if (w.start_request && !prev_req) begin
            freq_pos = stp;
            acc = 0;
            rmax = -32768;
            rmin = 32767;
            finished = 1'b0;
            scan = SCAN_NEXT;
          end
          prev_req = w.start_request;
        end
        SCAN_RUN: begin
          nxt = acc + step;
          if (nxt < acc) begin
            nxt = 0;
            wrapped = 1'b1;
          end
          acc = nxt;
          drive = drive_of(acc);
          if (sample > rmax) rmax = sample;
          if (sample < rmin) rmin = sample;
          diff = 32'(rmax - rmin) >> 1;
          held_amp = (diff > 32'h7FFF) ? 15'h7FFF : diff[14:0];
          if (pticks != 32'hFFFF_FFFF) pticks++;
          if (pticks > plen && wrapped) begin
            pticks = 0;
            acc = 0;
            drive = 0;
            rmax = -32768;
            rmin = 32767;
            wrapped = 1'b0;
            scan = SCAN_NEXT;
            pdone = 1'b1;
          end
        end
        SCAN_NEXT: begin
          if (freq_pos < ed) begin
            freq_pos = freq_pos + int'(lstep_q);
            if (freq_pos > 32767) freq_pos = 32767;
            step = phase_inc(freq_pos);
            plen = point_len(step);
            pticks = 0;
            wrapped = 1'b0;
            scan = SCAN_RUN;
          end else begin
            freq_pos = stp;
            scan = SCAN_FINISH;
          end
        end
        default: begin
          scan = SCAN_OFF;
          mode_q = MODE_OFF;
          sdone = 1'b1;
          finished = 1'b1;
        end
      endcase
    end
    res.drive_sample = 16'(drive);
    res.current_log_freq = 16'(freq_pos);
    res.response_amplitude = held_amp;
    res.point_done = pdone;
    res.sweep_done = sdone;
  endtask

  // watch the channels, predict on every input word, compare on every result word
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w, got_w;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      mode_q = MODE_CONT;
      amp_q = 15'd3;
      start_q = -16'sd8192;
      stop_q = 16'sd8192;
      lstep_q = 13'd410;
      ticks_q = 32'd50000;
      period_q = 30'd1000000;
      acc = 0; step = 0; elapsed = 0; pticks = 0; plen = 0;
      freq_pos = 0; rmax = -32768; rmin = 32767;
      held_amp = 0; wrapped = 0; prev_req = 0; finished = 0;
      scan = SCAN_OFF;
      expected_words.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SWEEP_MODE:  mode_q = cfg_data_i[1:0];
          REG_DRIVE_AMP:   amp_q = cfg_data_i[14:0];
          REG_START_LOG:   start_q = cfg_data_i[15:0];
          REG_STOP_LOG:    stop_q = cfg_data_i[15:0];
          REG_LOG_STEP:    lstep_q = cfg_data_i[12:0];
          REG_SWEEP_TICKS: ticks_q = cfg_data_i;
          REG_TICK_PERIOD: period_q = cfg_data_i[29:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        meter_tick(in_word_i, exp_w);
        expected_words.push_back(exp_w);
      end
      if (out_valid_i && out_ready_i) begin
        got_w = out_word_i;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w.drive_sample !== exp_w.drive_sample) begin
            $error("drive_sample: expected %0d, got %0d", exp_w.drive_sample,
                   got_w.drive_sample);
            errs++;
          end
          if (got_w.current_log_freq !== exp_w.current_log_freq) begin
            $error("current_log_freq: expected %0d, got %0d", exp_w.current_log_freq,
                   got_w.current_log_freq);
            errs++;
          end
          if (got_w.response_amplitude !== exp_w.response_amplitude) begin
            $error("response_amplitude: expected %0d, got %0d",
                   exp_w.response_amplitude, got_w.response_amplitude);
            errs++;
          end
          if (got_w.point_done !== exp_w.point_done) begin
            $error("point_done: expected %0b, got %0b", exp_w.point_done,
                   got_w.point_done);
            errs++;
          end
          if (got_w.sweep_done !== exp_w.sweep_done) begin
            $error("sweep_done: expected %0b, got %0b", exp_w.sweep_done,
                   got_w.sweep_done);
            errs++;
          end
        end
      end
      if (errs != 0) errors_o <= errors_o + errs;
      pending_o <= expected_words.size();
    end
  end

endmodule

FILE: tb/tb.sv
// testbench top of the log sine sweep response meter: clock, reset, stimulus
// and verdict; depends on lssrm_pkg, lssrm_checker and the core
`timescale 1ns / 1ps

module tb;
  import lssrm_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 30000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SWEEP_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pending, errors;
  int                    send_idle = 0, recv_idle = 0;
  int                    words_sent = 0, results_seen = 0, scans_done = 0, points_done = 0;
  int                    stall_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  log_sine_sweep_response_meter_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lssrm_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  // receiver stalls and result bookkeeping
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_word.sweep_done) scans_done <= scans_done + 1;
        if (out_word.point_done) points_done <= points_done + 1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic signed [15:0] sample, input logic req);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word.response_sample <= sample;
    in_word.start_request <= req;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender holds off until every expected word has come back
  task automatic hold_off();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // idle core before any register write
  task automatic drain();
    hold_off();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cont_sweep(input int lo, input int hi, input logic [31:0] ticks,
                            input int period, input int amp, input int n);
    set_reg(REG_DRIVE_AMP, amp);
    set_reg(REG_START_LOG, 32'(lo));
    set_reg(REG_STOP_LOG, 32'(hi));
    set_reg(REG_SWEEP_TICKS, ticks);
    set_reg(REG_TICK_PERIOD, period);
    set_reg(REG_SWEEP_MODE, 32'(MODE_CONT));
    end_cfg();
    repeat (n) send_word(rand_sample(), 1'($urandom));
    drain();
  endtask

  // stepped scan: trigger edge then words until the scan reports done or the cap is hit
  task automatic stepped_scan(input int lo, input int hi, input int lstep,
                              input int period, input int amp, input int cap);
    int base, n, pause_at;
    base = scans_done;
    n = 0;
    pause_at = $urandom_range(cap / 2, 3);
    set_reg(REG_DRIVE_AMP, amp);
    set_reg(REG_START_LOG, 32'(lo));
    set_reg(REG_STOP_LOG, 32'(hi));
    set_reg(REG_LOG_STEP, lstep);
    set_reg(REG_TICK_PERIOD, period);
    set_reg(REG_SWEEP_MODE, 32'(MODE_STEPPED));
    end_cfg();
    send_word(rand_sample(), 1'b0);
    send_word(rand_sample(), 1'b1);
    while (scans_done == base && n < cap) begin
      if (n == pause_at) hold_off();
      send_word(rand_sample(), ($urandom_range(3) != 0));
      n++;
    end
    repeat (2) send_word(rand_sample(), 1'($urandom));
    drain();
  endtask

  task automatic random_phase(input int count);
    int target, lo, hi, lstep, period;
    real base;
    target = words_sent + count;
    while (words_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          lo = $urandom_range(32768) - 16384;
          hi = $urandom_range(32768) - 16384;
          cont_sweep(lo, hi, ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(30, 1),
                     $urandom_range(1000000000, 1), $urandom_range(32767), 0);
          // word count is random, not tied to the sweep ticks just written
          repeat ($urandom_range(34, 4)) send_word(rand_sample(), 1'($urandom));
          drain();
        end
        4, 5, 6, 7, 8: begin
          lo = $urandom_range(20480) - 4096;
          hi = lo + $urandom_range(16384, 1);
          if (hi > 16384) hi = 16384;
          lstep = (hi - lo) / $urandom_range(5, 1) + 1;
          if (lstep > 4096) lstep = 4096;
          base = 1.0e8 / (10.0 ** (lo / 4096.0));
          period = int'(base) * $urandom_range(6, 1);
          if (period > 1000000000 || period < 1) period = 1000000000;
          stepped_scan(lo, hi, lstep, period, $urandom_range(32767), 500);
        end
        default: begin
          set_reg(REG_SWEEP_MODE, ($urandom_range(1) != 0) ? 32'd3 : 32'(MODE_OFF));
          end_cfg();
          repeat ($urandom_range(8, 2)) send_word(rand_sample(), 1'($urandom));
          drain();
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero sweep ticks, widest exponent range, full amplitude
    set_reg(REG_LOG_STEP, 32'd1);
    cont_sweep(-16384, 16384, 32'd0, 1, 32767, 1);
    // short continuous sweep at the longest tick period, zero amplitude, then idle words
    cont_sweep(-16384, 16384, 32'd4, 1000000000, 0, 7);
    // longest sweep, interrupted by a mode write that keeps the state
    cont_sweep(16384, -16384, 32'hFFFF_FFFF, 1000000000, 32767, 3);
    set_reg(REG_SWEEP_MODE, 32'd3);
    end_cfg();
    send_word(16'sh7FFF, 1'b1);
    send_word(16'sh8000, 1'b0);
    drain();
    // stepped scan whose exponent saturates at the top
    stepped_scan(28000, 32767, 4096, 1000000000, 32767, 40);

    // random part under three idling profiles
    send_idle = 33;
    recv_idle = 62;
    random_phase(330);
    send_idle = 62;
    recv_idle = 33;
    random_phase(330);
    send_idle = 0;
    recv_idle = 0;
    random_phase(330);

    // frequency too low for any phase step: point never ends until mode change
    set_reg(REG_START_LOG, -32'sd16384);
    set_reg(REG_STOP_LOG, -32'sd16000);
    set_reg(REG_LOG_STEP, 32'd1);
    set_reg(REG_TICK_PERIOD, 32'd1);
    set_reg(REG_SWEEP_MODE, 32'(MODE_STEPPED));
    end_cfg();
    send_word(rand_sample(), 1'b0);
    repeat (15) send_word(rand_sample(), 1'b1);
    drain();
    set_reg(REG_SWEEP_MODE, 32'(MODE_OFF));
    end_cfg();
    repeat (3) send_word(rand_sample(), 1'($urandom));
    drain();

    $display("covered continuous, stepped and off modes: %0d words in, %0d results",
             words_sent, results_seen);
    $display("%0d scans and %0d stepped points completed", scans_done, points_done);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lssrm_pkg.sv
hw/rtl/lssrm_div.sv
hw/rtl/lssrm_ctrl.sv
hw/rtl/lssrm_dp.sv
hw/rtl/log_sine_sweep_response_meter_core.sv
tb/lssrm_checker.sv
tb/tb.sv
